// ----- hdl/ascon_aead_cipher_top_macros.svh -----
// ---------------------------------------------------------------------------
// Ascon AEAD assertion macros
// Shared assertion forms used by the cipher modules.
// ---------------------------------------------------------------------------
`ifndef ASCON_AEAD_CIPHER_TOP_MACROS_SVH
`define ASCON_AEAD_CIPHER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASC_ASSERT_IMP(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASC_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/ascon_pkg.sv -----
// ---------------------------------------------------------------------------
// Ascon AEAD package
// Constants, codes and helper functions shared by the cipher modules.
// ---------------------------------------------------------------------------
package ascon_pkg;

  localparam logic [63:0] IV_128  = 64'h80400c0600000000;
  localparam logic [63:0] IV_128A = 64'h80800c0800000000;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_AD    = 2'd1,
    OP_TEXT  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_STARTED = 2'd1,
    PH_AD      = 2'd2,
    PH_TEXT    = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    CFG_MODE    = 3'd0,
    CFG_DIR     = 3'd1,
    CFG_KEY_HI  = 3'd2,
    CFG_KEY_LO  = 3'd3,
    CFG_NONCE_HI = 3'd4,
    CFG_NONCE_LO = 3'd5,
    CFG_TAG_HI  = 3'd6,
    CFG_TAG_LO  = 3'd7
  } cfg_idx_t;

  // Control from the sequencer to the round unit.
  typedef struct packed {
    logic       go;
    logic [3:0] first;
  } perm_ctl_t;

  function automatic logic [63:0] byte_mask(input logic [3:0] n);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (i < n) begin
        m[63-8*i -: 8] = 8'hff;
      end
    end
    return m;
  endfunction

  function automatic logic [63:0] pad_at(input logic [2:0] n);
    logic [63:0] p;
    p = '0;
    p[63 - 8*n] = 1'b1;
    return p;
  endfunction

  function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

endpackage

// ----- hdl/ascon_aead_cipher_top.sv -----
// A start and a full associated-data block pass through S_PERM and S_POST back to idle;
// a text block absorbs in S_POST and waits in S_OUT, or in S_FIN for the tag after a last
// block, before its result. A last associated-data block runs its padded block through S_PERM.
// Domain separation adds a pass through S_POST, a padded empty associated-data block S_PERM.
// One item is in flight at a time; the next beat waits until the result beat has gone.
// Reset is synchronous and clears the state, phase, configuration and handshake flags.
// ---------------------------------------------------------------------------
// Ascon AEAD cipher top level
// Sequences Ascon-128 and Ascon-128a encryption and decryption around a
// round unit, with a result register towards the output channel.
// ---------------------------------------------------------------------------
module ascon_aead_cipher_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [63:0] data_hi,
  input  logic [63:0] data_lo,
  input  logic [4:0]  byte_count,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_hi,
  output logic [63:0] out_lo,
  output logic [4:0]  out_bytes,
  output logic        tag_valid,
  output logic [63:0] tag_hi,
  output logic [63:0] tag_lo,
  output logic        tag_match
);
  import ascon_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PERM = 5'b00010,
    S_POST = 5'b00100,
    S_FIN  = 5'b01000,
    S_OUT  = 5'b10000
  } st_t;

  logic        mode, dir;
  logic [63:0] key_hi, key_lo, nonce_hi, nonce_lo, exp_hi, exp_lo;
  st_t         st;
  phase_t      phase;
  logic [1:0]  op;
  logic [63:0] dhi, dlo;
  logic [4:0]  cnt;
  logic        lst;
  logic        ad_fix;

  perm_ctl_t    ctl;
  logic         load, busy;
  logic [319:0] load_state, state;

  logic [63:0] x0, x1, x2, x3, x4;
  assign {x0, x1, x2, x3, x4} = state;

  logic [3:0] first;
  logic [4:0] rate;
  assign first = mode ? 4'd4 : 4'd6;
  assign rate  = mode ? 5'd16 : 5'd8;

  logic [4:0]  n;
  logic [63:0] m0, m1, d0, d1;
  always_comb begin
    n  = (cnt >= rate) ? rate - 5'd1 : cnt;
    m0 = byte_mask((n > 5'd8) ? 4'd8 : n[3:0]);
    m1 = mode ? byte_mask((n > 5'd8) ? 4'(n - 5'd8) : 4'd0) : 64'd0;
    d0 = dhi & m0;
    d1 = dlo & m1;
  end

  assign in_ready = (st == S_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0; dir <= 1'b0;
      key_hi <= '0; key_lo <= '0; nonce_hi <= '0; nonce_lo <= '0;
      exp_hi <= '0; exp_lo <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MODE:     mode <= cfg_data[0];
        CFG_DIR:      dir <= cfg_data[0];
        CFG_KEY_HI:   key_hi <= cfg_data;
        CFG_KEY_LO:   key_lo <= cfg_data;
        CFG_NONCE_HI: nonce_hi <= cfg_data;
        CFG_NONCE_LO: nonce_lo <= cfg_data;
        CFG_TAG_HI:   exp_hi <= cfg_data;
        CFG_TAG_LO:   exp_lo <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    load       = 1'b0;
    ctl.go     = 1'b0;
    ctl.first  = first;
    load_state = state;
    unique case (st)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          priority case (op_t'(operation))
            OP_START: begin
              load = 1'b1; ctl.go = 1'b1; ctl.first = 4'd0;
              load_state = {mode ? IV_128A : IV_128, key_hi, key_lo, nonce_hi, nonce_lo};
            end
            OP_AD: begin
              if ((phase == PH_STARTED || phase == PH_AD) && !last) begin
                load = 1'b1; ctl.go = 1'b1;
                load_state = {x0 ^ data_hi, mode ? x1 ^ data_lo : x1, x2, x3, x4};
              end
            end
            OP_TEXT: begin
              if (phase == PH_AD) begin
                load = 1'b1; ctl.go = 1'b1;
                load_state = {x0 ^ pad_at(3'd0), x1, x2, x3, x4};
              end
            end
            default: ;
          endcase
        end
      end
      S_POST: begin
        load = 1'b1;
        priority if (op == OP_START) begin
          load_state = {x0, x1, x2, x3 ^ key_hi, x4 ^ key_lo};
        end else if (op == OP_AD) begin
          if (lst && !ad_fix && !(phase == PH_STARTED && n == 5'd0)) begin
            ctl.go = 1'b1;
            load_state = (n < 5'd8) ?
              {x0 ^ d0 ^ pad_at(n[2:0]), x1 ^ d1, x2, x3, x4} :
              {x0 ^ d0, x1 ^ d1 ^ pad_at(n[2:0]), x2, x3, x4};
          end else if (lst) begin
            load_state = {x0, x1, x2, x3, x4 ^ 64'd1};
          end
        end else if (ad_fix) begin
          load_state = {x0, x1, x2, x3, x4 ^ 64'd1};
        end else if (!lst) begin
          ctl.go = 1'b1;
          load_state = {dir ? dhi : x0 ^ dhi,
                        mode ? (dir ? dlo : x1 ^ dlo) : x1, x2, x3, x4};
        end else begin
          logic [63:0] y0, y1, y2;
          y0 = dir ? ((x0 & ~m0) | d0) : x0 ^ d0;
          y1 = dir ? ((x1 & ~m1) | d1) : x1 ^ d1;
          if (n < 5'd8) y0 = y0 ^ pad_at(n[2:0]);
          else          y1 = y1 ^ pad_at(n[2:0]);
          y2 = x2;
          ctl.go = 1'b1; ctl.first = 4'd0;
          load_state = mode ? {y0, y1, y2 ^ key_hi, x3 ^ key_lo, x4}
                            : {y0, y1 ^ key_hi, y2 ^ key_lo, x3, x4};
        end
      end
      S_FIN: begin
        load = !busy;
        load_state = {x0, x1, x2, x3 ^ key_hi, x4 ^ key_lo};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE; phase <= PH_IDLE; out_valid <= 1'b0; ad_fix <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (st)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            op <= operation; dhi <= data_hi; dlo <= data_lo;
            cnt <= byte_count; lst <= last;
            ad_fix <= (op_t'(operation) == OP_TEXT) &&
                      (phase == PH_AD || phase == PH_STARTED);
            priority case (op_t'(operation))
              OP_START: st <= S_PERM;
              OP_AD: begin
                if (phase == PH_STARTED || phase == PH_AD) st <= last ? S_POST : S_PERM;
              end
              OP_TEXT: begin
                if (phase == PH_AD) begin
                  st <= S_PERM;
                end else if (phase != PH_IDLE) begin
                  st <= S_POST;
                end
              end
              default: ;
            endcase
          end
        end
        S_PERM: if (!busy) st <= S_POST;
        S_POST: begin
          priority if (op == OP_START) begin
            phase <= PH_STARTED; st <= S_IDLE;
          end else if (op == OP_AD) begin
            if (lst && !ad_fix && !(phase == PH_STARTED && n == 5'd0)) begin
              ad_fix <= 1'b1; st <= S_PERM;
            end else begin
              phase <= lst ? PH_TEXT : PH_AD; st <= S_IDLE; ad_fix <= 1'b0;
            end
          end else if (ad_fix) begin
            ad_fix <= 1'b0; phase <= PH_TEXT;
          end else begin
            phase <= PH_TEXT;
            tag_valid <= 1'b0; tag_hi <= '0; tag_lo <= '0; tag_match <= 1'b0;
            if (!lst) begin
              out_hi <= x0 ^ dhi; out_lo <= mode ? x1 ^ dlo : 64'd0;
              out_bytes <= rate; st <= S_OUT;
            end else begin
              out_hi <= (x0 ^ d0) & m0; out_lo <= (x1 ^ d1) & m1;
              out_bytes <= n; st <= S_FIN;
            end
          end
        end
        S_FIN: if (!busy) begin
          tag_valid <= 1'b1;
          tag_hi    <= dir ? 64'd0 : x3 ^ key_hi;
          tag_lo    <= dir ? 64'd0 : x4 ^ key_lo;
          tag_match <= dir && (x3 ^ key_hi) == exp_hi && (x4 ^ key_lo) == exp_lo;
          phase     <= PH_IDLE;
          out_valid <= 1'b1;
          st        <= S_IDLE;
        end
        S_OUT: if (!busy) begin
          out_valid <= 1'b1; st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  ascon_round u_round (
    .clk(clk), .rst(rst), .ctl(ctl), .load(load),
    .load_state(load_state), .state(state), .busy(busy)
  );

  `include "ascon_aead_cipher_top_macros.svh"
  `ASC_ASSERT_IMP(a_onehot, clk, rst, 1'b1, $onehot(st), "state not one-hot")
  `ASC_ASSERT_IMP(a_no_accept_busy, clk, rst, in_valid && in_ready, !busy,
    "item taken while rounds run")
  `ASC_ASSERT_NEXT(a_fin_phase, clk, rst, st == S_FIN && !busy,
    phase == PH_IDLE && out_valid, "finalisation did not close message")
endmodule

// ----- hdl/ascon_round.sv -----
// ---------------------------------------------------------------------------
// Ascon round unit
// Holds the 320-bit state and applies one permutation round per cycle while busy and not loading.
// ---------------------------------------------------------------------------
module ascon_round (
  input  logic                  clk,
  input  logic                  rst,
  input  ascon_pkg::perm_ctl_t  ctl,
  input  logic                  load,
  input  logic [319:0]          load_state,
  output logic [319:0]          state,
  output logic                  busy
);
  import ascon_pkg::*;

  logic [3:0]   rnd;
  logic [319:0] rnd_out;

  always_comb begin
    logic [63:0] x0, x1, x2, x3, x4, t0, t1, t2, t3, t4;
    x0 = state[319:256];
    x1 = state[255:192];
    x2 = state[191:128];
    x3 = state[127:64];
    x4 = state[63:0];
    x2 = x2 ^ {56'd0, 4'hf - rnd, rnd};
    x0 = x0 ^ x4; x4 = x4 ^ x3; x2 = x2 ^ x1;
    t0 = ~x0 & x1; t1 = ~x1 & x2; t2 = ~x2 & x3; t3 = ~x3 & x4; t4 = ~x4 & x0;
    x0 = x0 ^ t1; x1 = x1 ^ t2; x2 = x2 ^ t3; x3 = x3 ^ t4; x4 = x4 ^ t0;
    x1 = x1 ^ x0; x0 = x0 ^ x4; x3 = x3 ^ x2; x2 = ~x2;
    x0 = x0 ^ rotr(x0, 19) ^ rotr(x0, 28);
    x1 = x1 ^ rotr(x1, 61) ^ rotr(x1, 39);
    x2 = x2 ^ rotr(x2, 1) ^ rotr(x2, 6);
    x3 = x3 ^ rotr(x3, 10) ^ rotr(x3, 17);
    x4 = x4 ^ rotr(x4, 7) ^ rotr(x4, 41);
    rnd_out = {x0, x1, x2, x3, x4};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      rnd   <= '0;
      state <= '0;
    end else if (load) begin
      state <= load_state;
      if (ctl.go) begin
        busy <= 1'b1;
        rnd  <= ctl.first;
      end
    end else if (busy) begin
      state <= rnd_out;
      rnd   <= rnd + 4'd1;
      if (rnd == 4'd11) begin
        busy <= 1'b0;
      end
    end
  end

  `include "ascon_aead_cipher_top_macros.svh"
  `ASC_ASSERT_IMP(a_rnd_range, clk, rst, busy, rnd <= 4'd11, "round index out of range")
  `ASC_ASSERT_NEXT(a_go_busy, clk, rst, load && ctl.go, busy, "permutation did not start")
  `ASC_ASSERT_NEXT(a_end, clk, rst, busy && rnd == 4'd11 && !load, !busy, "permutation overran")
endmodule

// ----- verif/tb_ascon_aead_cipher_top.sv -----
// ---------------------------------------------------------------------------
// Ascon AEAD cipher testbench
// Drives start, associated-data and text beats into the cipher under both
// modes and directions. Every result beat is checked against a behavioural
// model of the sponge that is kept in step with the accepted input beats.
// A short table of hand-picked beats runs first. Random messages follow,
// some of them decrypting ciphertext whose tag was predicted beforehand.
// ---------------------------------------------------------------------------
module tb_ascon_aead_cipher_top;
  import ascon_pkg::*;

  typedef struct packed {
    logic        mode;
    logic        dir;
    logic [63:0] key_hi;
    logic [63:0] key_lo;
    logic [63:0] nonce_hi;
    logic [63:0] nonce_lo;
    logic [63:0] tag_hi;
    logic [63:0] tag_lo;
  } cipher_cfg_t;

  typedef struct packed {
    phase_t           ph;
    logic [4:0][63:0] ln;
  } sponge_t;

  typedef struct packed {
    op_t         op;
    logic [63:0] dhi;
    logic [63:0] dlo;
    logic [4:0]  cnt;
    logic        last;
  } block_t;

  typedef struct packed {
    logic [63:0] out_hi;
    logic [63:0] out_lo;
    logic [4:0]  out_bytes;
    logic        tag_valid;
    logic [63:0] tag_hi;
    logic [63:0] tag_lo;
    logic        tag_match;
  } text_beat_t;

  typedef struct packed {
    logic       wide;
    block_t     blk;
    logic       quiet;
    logic [5:0] want_bytes;
  } hand_row_t;

  localparam logic [5:0] UNTYPED = 6'h3f;
  localparam logic [63:0] ONES = 64'hffff_ffff_ffff_ffff;
  localparam int SETTLE = 60;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  operation = '0;
  logic [63:0] data_hi = '0;
  logic [63:0] data_lo = '0;
  logic [4:0]  byte_count = '0;
  logic        last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_hi;
  logic [63:0] out_lo;
  logic [4:0]  out_bytes;
  logic        tag_valid;
  logic [63:0] tag_hi;
  logic [63:0] tag_lo;
  logic        tag_match;

  cipher_cfg_t cur_cfg;
  sponge_t     sponge;
  text_beat_t  awaited_beats[$];
  int          mismatches = 0;
  int          blocks_sent = 0;
  bit          tx_burst = 0;
  bit          rx_burst = 0;

  ascon_aead_cipher_top u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .operation(operation),
    .data_hi(data_hi), .data_lo(data_lo), .byte_count(byte_count), .last(last),
    .out_valid(out_valid), .out_ready(out_ready), .out_hi(out_hi), .out_lo(out_lo),
    .out_bytes(out_bytes), .tag_valid(tag_valid), .tag_hi(tag_hi), .tag_lo(tag_lo),
    .tag_match(tag_match)
  );

  always #10 clk = ~clk;

  function automatic logic [63:0] ror64(input logic [63:0] x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  function automatic logic [63:0] lead_mask(input int n);
    if (n <= 0) return 64'd0;
    if (n >= 8) return ONES;
    return ONES << (64 - 8 * n);
  endfunction

  function automatic logic [63:0] pad_bit(input int n);
    return 64'h80 << (56 - 8 * (n % 8));
  endfunction

  function automatic void ascon_rounds(inout logic [4:0][63:0] x, input int first);
    logic [63:0] t0, t1, t2, t3, t4;
    for (int r = first; r < 12; r++) begin
      x[2] ^= 64'(((15 - r) << 4) | r);
      x[0] ^= x[4]; x[4] ^= x[3]; x[2] ^= x[1];
      t0 = ~x[0] & x[1]; t1 = ~x[1] & x[2]; t2 = ~x[2] & x[3];
      t3 = ~x[3] & x[4]; t4 = ~x[4] & x[0];
      x[0] ^= t1; x[1] ^= t2; x[2] ^= t3; x[3] ^= t4; x[4] ^= t0;
      x[1] ^= x[0]; x[0] ^= x[4]; x[3] ^= x[2]; x[2] = ~x[2];
      x[0] ^= ror64(x[0], 19) ^ ror64(x[0], 28);
      x[1] ^= ror64(x[1], 61) ^ ror64(x[1], 39);
      x[2] ^= ror64(x[2], 1) ^ ror64(x[2], 6);
      x[3] ^= ror64(x[3], 10) ^ ror64(x[3], 17);
      x[4] ^= ror64(x[4], 7) ^ ror64(x[4], 41);
    end
  endfunction

  // Advances the sponge by one block and reports whether a text beat results.
  function automatic bit absorb_block(inout sponge_t s, input cipher_cfg_t c,
                                      input block_t b, output text_beat_t r);
    bit          wide;
    int          rate, first, n;
    logic [63:0] m0, m1, d0, d1, c1;
    wide  = c.mode;
    rate  = wide ? 16 : 8;
    first = wide ? 4 : 6;
    r = '0;
    n = (b.cnt >= rate) ? rate - 1 : int'(b.cnt);
    m0 = lead_mask(n > 8 ? 8 : n);
    m1 = wide ? lead_mask(n > 8 ? n - 8 : 0) : 64'd0;
    case (b.op)
      OP_START: begin
        s.ln[0] = wide ? IV_128A : IV_128;
        s.ln[1] = c.key_hi; s.ln[2] = c.key_lo;
        s.ln[3] = c.nonce_hi; s.ln[4] = c.nonce_lo;
        ascon_rounds(s.ln, 0);
        s.ln[3] ^= c.key_hi; s.ln[4] ^= c.key_lo;
        s.ph = PH_STARTED;
        return 0;
      end
      OP_AD: begin
        if (s.ph != PH_STARTED && s.ph != PH_AD) return 0;
        if (!b.last) begin
          s.ln[0] ^= b.dhi;
          if (wide) s.ln[1] ^= b.dlo;
          ascon_rounds(s.ln, first);
          s.ph = PH_AD;
          return 0;
        end
        if (!(s.ph == PH_STARTED && n == 0)) begin
          s.ln[0] ^= b.dhi & m0;
          s.ln[1] ^= b.dlo & m1;
          if (n < 8) s.ln[0] ^= pad_bit(n); else s.ln[1] ^= pad_bit(n - 8);
          ascon_rounds(s.ln, first);
        end
        s.ln[4] ^= 64'd1;
        s.ph = PH_TEXT;
        return 0;
      end
      OP_TEXT: begin
        if (s.ph == PH_IDLE) return 0;
      end
      default: return 0;
    endcase
    if (s.ph == PH_AD) begin
      s.ln[0] ^= pad_bit(0);
      ascon_rounds(s.ln, first);
    end
    if (s.ph != PH_TEXT) begin
      s.ln[4] ^= 64'd1;
      s.ph = PH_TEXT;
    end
    if (!b.last) begin
      c1 = wide ? b.dlo : 64'd0;
      r.out_hi = s.ln[0] ^ b.dhi;
      r.out_lo = wide ? (s.ln[1] ^ c1) : 64'd0;
      if (c.dir) begin
        s.ln[0] = b.dhi;
        if (wide) s.ln[1] = c1;
      end else begin
        s.ln[0] ^= b.dhi;
        if (wide) s.ln[1] ^= c1;
      end
      r.out_bytes = 5'(rate);
      ascon_rounds(s.ln, first);
      return 1;
    end
    d0 = b.dhi & m0;
    d1 = b.dlo & m1;
    r.out_hi = (s.ln[0] ^ d0) & m0;
    r.out_lo = (s.ln[1] ^ d1) & m1;
    if (c.dir) begin
      s.ln[0] = (s.ln[0] & ~m0) | d0;
      s.ln[1] = (s.ln[1] & ~m1) | d1;
    end else begin
      s.ln[0] ^= d0;
      s.ln[1] ^= d1;
    end
    if (n < 8) s.ln[0] ^= pad_bit(n); else s.ln[1] ^= pad_bit(n - 8);
    r.out_bytes = 5'(n);
    if (wide) begin
      s.ln[2] ^= c.key_hi; s.ln[3] ^= c.key_lo;
    end else begin
      s.ln[1] ^= c.key_hi; s.ln[2] ^= c.key_lo;
    end
    ascon_rounds(s.ln, 0);
    s.ln[3] ^= c.key_hi; s.ln[4] ^= c.key_lo;
    r.tag_valid = 1'b1;
    if (c.dir) begin
      r.tag_match = (s.ln[3] == c.tag_hi && s.ln[4] == c.tag_lo);
    end else begin
      r.tag_hi = s.ln[3];
      r.tag_lo = s.ln[4];
    end
    s.ph = PH_IDLE;
    return 1;
  endfunction

  function automatic void flag(input string what);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH at %0t: %s", $realtime, what);
  endfunction

  task automatic write_cfg(input cipher_cfg_t c);
    logic [63:0] v;
    for (int i = 0; i < 8; i++) begin
      case (cfg_idx_t'(i))
        CFG_MODE:     v = 64'(c.mode);
        CFG_DIR:      v = 64'(c.dir);
        CFG_KEY_HI:   v = c.key_hi;
        CFG_KEY_LO:   v = c.key_lo;
        CFG_NONCE_HI: v = c.nonce_hi;
        CFG_NONCE_LO: v = c.nonce_lo;
        CFG_TAG_HI:   v = c.tag_hi;
        default:      v = c.tag_lo;
      endcase
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= v;
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    cur_cfg = c;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (awaited_beats.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_block(input block_t b, output bit made, output text_beat_t r);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    operation <= b.op;
    data_hi <= b.dhi;
    data_lo <= b.dlo;
    byte_count <= b.cnt;
    last <= b.last;
    do @(posedge clk); while (!in_ready);
    made = absorb_block(sponge, cur_cfg, b, r);
    if (made) awaited_beats.push_back(r);
    if (b.op != OP_NONE) blocks_sent++;
    @(negedge clk);
  endtask

  function automatic block_t rand_block(input op_t op, input bit fin);
    block_t b;
    b.op = op;
    b.dhi = {$urandom, $urandom};
    b.dlo = {$urandom, $urandom};
    b.cnt = 5'($urandom_range(0, 16));
    b.last = fin;
    return b;
  endfunction

  // One message; a decryption may be built to carry a matching tag.
  task automatic run_message(input bit forge_match);
    block_t      msg[$];
    block_t      b;
    sponge_t     shadow;
    cipher_cfg_t enc;
    text_beat_t  r;
    bit          made;
    int          n_ad, n_tx;
    n_ad = $urandom_range(0, 3);
    n_tx = $urandom_range(0, 3);
    msg.push_back(rand_block(OP_START, 1'b0));
    for (int i = 0; i < n_ad; i++) msg.push_back(rand_block(OP_AD, 1'b0));
    if ($urandom_range(0, 3) != 0) msg.push_back(rand_block(OP_AD, 1'b1));
    for (int i = 0; i < n_tx; i++) msg.push_back(rand_block(OP_TEXT, 1'b0));
    msg.push_back(rand_block(OP_TEXT, 1'b1));
    if (forge_match) begin
      enc = cur_cfg;
      enc.dir = 1'b0;
      shadow = '0;
      foreach (msg[i]) begin
        if (absorb_block(shadow, enc, msg[i], r)) begin
          msg[i].dhi = r.out_hi;
          msg[i].dlo = r.out_lo;
          if (r.tag_valid) begin
            enc.dir = 1'b1;
            enc.tag_hi = r.tag_hi;
            enc.tag_lo = r.tag_lo;
          end
        end
      end
      drain();
      write_cfg(enc);
    end
    foreach (msg[i]) begin
      if ($urandom_range(0, 9) == 0) begin
        b = rand_block(op_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
        send_block(b, made, r);
      end
      send_block(msg[i], made, r);
    end
  endtask

  always @(posedge clk) begin
    text_beat_t want, seen;
    if (!rst && out_valid && out_ready) begin
      seen = '{out_hi, out_lo, out_bytes, tag_valid, tag_hi, tag_lo, tag_match};
      if (awaited_beats.size() == 0) begin
        flag("result beat with none expected");
      end else begin
        want = awaited_beats.pop_front();
        if (seen !== want) begin
          flag($sformatf({"exp out %h_%h bytes %0d tv %b tag %h_%h match %b / ",
                          "got out %h_%h bytes %0d tv %b tag %h_%h match %b"},
                         want.out_hi, want.out_lo, want.out_bytes, want.tag_valid,
                         want.tag_hi, want.tag_lo, want.tag_match,
                         seen.out_hi, seen.out_lo, seen.out_bytes, seen.tag_valid,
                         seen.tag_hi, seen.tag_lo, seen.tag_match));
        end
      end
    end
  end

  initial begin
    int w;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      w = rx_burst ? 0 : $urandom_range(0, 8);
      if (w > 0) begin
        out_ready <= 1'b0;
        repeat (w) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    #20000000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    hand_row_t   rows[24];
    cipher_cfg_t c;
    text_beat_t  r;
    bit          made;
    int          setting;
    rows = '{
      '{1'b0, '{OP_TEXT, ONES, ONES, 5'd3, 1'b1}, 1'b1, UNTYPED},
      '{1'b0, '{OP_AD, ONES, ONES, 5'd3, 1'b1}, 1'b1, UNTYPED},
      '{1'b0, '{OP_NONE, ONES, ONES, 5'd31, 1'b1}, 1'b1, UNTYPED},
      '{1'b0, '{OP_START, 64'd0, 64'd0, 5'd0, 1'b0}, 1'b1, UNTYPED},
      '{1'b0, '{OP_AD, ONES, ONES, 5'd0, 1'b1}, 1'b1, UNTYPED},
      '{1'b0, '{OP_TEXT, ONES, ONES, 5'd0, 1'b0}, 1'b0, 6'd8},
      '{1'b0, '{OP_TEXT, ONES, ONES, 5'd16, 1'b1}, 1'b0, 6'd7},
      '{1'b0, '{OP_START, ONES, ONES, 5'd16, 1'b1}, 1'b1, UNTYPED},
      '{1'b0, '{OP_AD, 64'd0, 64'd0, 5'd16, 1'b0}, 1'b1, UNTYPED},
      '{1'b0, '{OP_TEXT, 64'd0, 64'd0, 5'd0, 1'b1}, 1'b0, 6'd0},
      '{1'b0, '{OP_AD, ONES, 64'd0, 5'd1, 1'b0}, 1'b1, UNTYPED},
      '{1'b0, '{OP_START, 64'd0, 64'd0, 5'd0, 1'b0}, 1'b1, UNTYPED},
      '{1'b0, '{OP_AD, 64'h0123456789abcdef, 64'd0, 5'd5, 1'b1}, 1'b1, UNTYPED},
      '{1'b0, '{OP_AD, ONES, ONES, 5'd2, 1'b1}, 1'b1, UNTYPED},
      '{1'b0, '{OP_START, 64'd0, 64'd0, 5'd0, 1'b0}, 1'b1, UNTYPED},
      '{1'b0, '{OP_TEXT, ONES, ONES, 5'd8, 1'b1}, 1'b0, 6'd7},
      '{1'b1, '{OP_START, 64'd0, 64'd0, 5'd0, 1'b0}, 1'b1, UNTYPED},
      '{1'b1, '{OP_AD, ONES, ONES, 5'd16, 1'b0}, 1'b1, UNTYPED},
      '{1'b1, '{OP_AD, ONES, ONES, 5'd9, 1'b1}, 1'b1, UNTYPED},
      '{1'b1, '{OP_TEXT, 64'h5a5a5a5a5a5a5a5a, ONES, 5'd4, 1'b0}, 1'b0, 6'd16},
      '{1'b1, '{OP_TEXT, ONES, ONES, 5'd15, 1'b1}, 1'b0, 6'd15},
      '{1'b1, '{OP_START, 64'd0, 64'd0, 5'd0, 1'b0}, 1'b1, UNTYPED},
      '{1'b1, '{OP_TEXT, ONES, ONES, 5'd16, 1'b1}, 1'b0, 6'd15},
      '{1'b1, '{OP_TEXT, ONES, ONES, 5'd0, 1'b0}, 1'b1, UNTYPED}
    };
    cur_cfg = '0;
    sponge = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (rows[i]) begin
      if (rows[i].wide != cur_cfg.mode) begin
        drain();
        c = cur_cfg;
        c.mode = rows[i].wide;
        c.key_hi = ONES;
        c.key_lo = ONES;
        write_cfg(c);
      end
      send_block(rows[i].blk, made, r);
      if (made == rows[i].quiet) flag($sformatf("table row %0d: result presence", i));
      if (made && rows[i].want_bytes != UNTYPED && 6'(r.out_bytes) != rows[i].want_bytes)
        flag($sformatf("table row %0d: byte count %0d", i, r.out_bytes));
    end

    setting = 0;
    while (blocks_sent < 700) begin
      drain();
      c.mode = 1'($urandom_range(0, 1));
      c.dir = 1'($urandom_range(0, 1));
      c.key_hi = {$urandom, $urandom};
      c.key_lo = {$urandom, $urandom};
      c.nonce_hi = {$urandom, $urandom};
      c.nonce_lo = {$urandom, $urandom};
      c.tag_hi = {$urandom, $urandom};
      c.tag_lo = {$urandom, $urandom};
      if (setting % 5 == 0) begin
        c.key_hi = '0; c.key_lo = '0; c.nonce_hi = '0; c.nonce_lo = '0;
        c.tag_hi = '0; c.tag_lo = '0;
      end else if (setting % 5 == 1) begin
        c.key_hi = ONES; c.key_lo = ONES; c.nonce_hi = ONES; c.nonce_lo = ONES;
        c.tag_hi = ONES; c.tag_lo = ONES;
      end
      write_cfg(c);
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(3, 6)) begin
        run_message(cur_cfg.dir && $urandom_range(0, 1));
      end
      setting++;
    end

    drain();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/ascon_pkg.sv
hdl/ascon_round.sv
hdl/ascon_aead_cipher_top.sv
verif/tb_ascon_aead_cipher_top.sv
